// ===== hdl/tmq_pkg.sv =====
// Package for the timed move command queue.
// Holds the payload, entry, result, state and datapath command/status types, the reset reload and the fill width.
// No dependencies.
`default_nettype none

package tmq_pkg;

    localparam logic [15:0] RESET_RELOAD = 16'd1000;
    localparam int          FILL_W       = 4;

    typedef enum logic [1:0] {
        KIND_ACCEPT   = 2'd0,
        KIND_REJECT   = 2'd1,
        KIND_NO_ISSUE = 2'd2,
        KIND_ISSUE    = 2'd3
    } t_kind;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  prop_index;
        logic [15:0] target_position;
        logic [15:0] travel_interval;
        logic [15:0] gesture_ticks;
    } t_move_req;

    typedef struct packed {
        t_kind             result_kind;
        logic [2:0]        out_prop;
        logic [15:0]       out_target;
        logic [15:0]       out_travel;
        logic [FILL_W-1:0] fill_before;
    } t_move_res;

    typedef struct packed {
        logic [2:0]  prop;
        logic [15:0] target;
        logic [15:0] travel;
        logic [15:0] gesture;
    } t_entry;

    typedef enum logic {
        S_IDLE,
        S_ISSUE
    } t_state;

    typedef struct packed {
        logic  wr_en;
        logic  cnt_dec;
        logic  cnt_reload;
        logic  rd_start;
        logic  issue;
        logic  res_load;
        t_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic req_enq;
        logic q_full;
        logic q_empty;
        logic cnt_zero;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/tmq_if.sv =====
// Valid/ready channel interfaces for move requests and queue results.
// Depends on tmq_pkg.
`default_nettype none

interface tmq_in_if import tmq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_move_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmq_out_if import tmq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_move_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tmq_ctrl.sv =====
// Controller of the timed move command queue: decodes each request transfer into datapath
// commands and issues a fetched move from S_ISSUE. Depends on tmq_pkg.
`default_nettype none

module tmq_ctrl import tmq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.res_kind = KIND_NO_ISSUE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_status.out_free && i_rst_n;
                if (i_in_valid && o_in_ready) begin
                    if (i_status.req_enq) begin
                        o_cmd.res_load = 1'b1;
                        if (i_status.q_full) begin
                            o_cmd.res_kind = KIND_REJECT;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.res_kind = KIND_ACCEPT;
                        end
                    end else if (!i_status.cnt_zero) begin
                        o_cmd.cnt_dec  = 1'b1;
                        o_cmd.res_load = 1'b1;
                    end else if (i_status.q_empty) begin
                        o_cmd.cnt_reload = 1'b1;
                        o_cmd.res_load   = 1'b1;
                    end else begin
                        // fetch the head entry; the result follows once the read lands
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (i_status.out_free) begin
                    o_cmd.issue    = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = KIND_ISSUE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tmq_datapath.sv =====
// Datapath of the timed move command queue: move store, ring pointers,
// countdown, reload register and result register. Depends on tmq_pkg.
`default_nettype none

module tmq_datapath import tmq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_move_req   i_req,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output logic             o_res_valid,
    output t_move_res        o_res,
    input  wire logic        i_res_ready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST  = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH = (AW + 1)'(QUEUE_DEPTH);

    t_entry        r_mem [QUEUE_DEPTH];
    t_entry        r_rd_data;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [15:0]   r_cnt, n_cnt;
    logic [15:0]   r_reload;
    logic          r_out_valid, n_out_valid;
    t_move_res     r_out_data, n_out_data;

    logic [AW-1:0]      wr_next, rd_next;
    logic [AW-1:0]      fill;
    logic [AW:0]        fill_wrap;
    logic [AW+FILL_W:0] fill_ext;
    logic               out_free;
    t_entry             wr_entry;

    assign wr_next   = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next   = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
    assign fill_wrap = {1'b0, r_wr_ptr} + DEPTH - {1'b0, r_rd_ptr};
    assign fill      = (r_wr_ptr >= r_rd_ptr) ? r_wr_ptr - r_rd_ptr : fill_wrap[AW-1:0];
    assign fill_ext  = {{(FILL_W + 1){1'b0}}, fill};
    assign out_free  = !r_out_valid || i_res_ready;

    assign wr_entry.prop    = i_req.prop_index;
    assign wr_entry.target  = i_req.target_position;
    assign wr_entry.travel  = i_req.travel_interval;
    assign wr_entry.gesture = i_req.gesture_ticks;

    assign o_status.out_free = out_free;
    assign o_status.req_enq  = i_req.req_type;
    assign o_status.q_full   = (wr_next == r_rd_ptr);
    assign o_status.q_empty  = (r_wr_ptr == r_rd_ptr);
    assign o_status.cnt_zero = (r_cnt == 16'd0);

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_wr_ptr] <= wr_entry;
        end
        if (i_cmd.rd_start) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (i_cmd.wr_en) begin
            n_wr_ptr = wr_next;
        end
        if (i_cmd.cnt_dec) begin
            n_cnt = r_cnt - 16'd1;
        end
        if (i_cmd.cnt_reload) begin
            n_cnt = r_reload;
        end
        if (i_cmd.issue) begin
            n_cnt    = r_rd_data.gesture;
            n_rd_ptr = rd_next;
        end

        // drop the result once the sink takes it
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.res_load) begin
            n_out_valid            = 1'b1;
            n_out_data             = '0;
            n_out_data.result_kind = i_cmd.res_kind;
            if (i_cmd.issue) begin
                n_out_data.out_prop    = r_rd_data.prop;
                n_out_data.out_target  = r_rd_data.target;
                n_out_data.out_travel  = r_rd_data.travel;
                n_out_data.fill_before = fill_ext[FILL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= RESET_RELOAD;
            r_reload    <= RESET_RELOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_reload <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> !o_status.q_full)
        else $error("store written while queue full");

    a_fetch_needs_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_start |-> !o_status.q_empty && o_status.cnt_zero)
        else $error("head fetched without an expired countdown and a queued move");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> out_free)
        else $error("pending result overwritten");

    a_issue_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |=> r_out_valid && (r_out_data.result_kind == KIND_ISSUE))
        else $error("issued move not presented");

endmodule

`default_nettype wire

// ===== hdl/timed_move_command_queue.sv =====
// Timed move command queue, top level.
// Results: enqueues and non-issuing ticks give their result in the cycle after transfer;
// a tick that issues a move passes through the registered store read, then the result register.
// Throughput: one item per cycle; an issuing tick holds input off while in S_ISSUE; a held result stalls input.
// Reset: pointers cleared, countdown and idle reload set to 1000, result register emptied;
// the move store is not cleared.
`default_nettype none

module timed_move_command_queue import tmq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    tmq_in_if.sink           i_in,
    tmq_out_if.source        o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       res_valid;
    t_move_res  res;

    tmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = res_valid;
    assign o_out.data  = res;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the timed move command queue: ticks and enqueues go in with random stalls
// on both channels, and every result is checked against a queue predictor kept in the bench.
// Depends on tmq_pkg, the tmq_if channel interfaces and the timed_move_command_queue top.
module testbench;
    import tmq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    tmq_in_if  in_if ();
    tmq_out_if out_if ();

    timed_move_command_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Predictor copy of the queue, timer and reload register
    t_entry      shadow_store [DEPTH];
    int          shadow_rd;
    int          shadow_wr;
    logic [15:0] shadow_countdown;
    logic [15:0] shadow_reload;

    t_move_res   pending_results [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int next_slot(input int idx);
        return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function automatic int queued_moves();
        return (shadow_wr + DEPTH - shadow_rd) % DEPTH;
    endfunction

    function automatic t_move_res predict_queue_result(input t_move_req req);
        t_move_res res;
        int        fill;
        res = '0;
        res.result_kind = KIND_NO_ISSUE;
        if (req.req_type) begin
            if (next_slot(shadow_wr) == shadow_rd) begin
                res.result_kind = KIND_REJECT;
            end else begin
                shadow_store[shadow_wr].prop    = req.prop_index;
                shadow_store[shadow_wr].target  = req.target_position;
                shadow_store[shadow_wr].travel  = req.travel_interval;
                shadow_store[shadow_wr].gesture = req.gesture_ticks;
                shadow_wr = next_slot(shadow_wr);
                res.result_kind = KIND_ACCEPT;
            end
        end else if (shadow_countdown != 16'd0) begin
            shadow_countdown = shadow_countdown - 16'd1;
        end else begin
            fill = queued_moves();
            shadow_countdown = shadow_reload;
            if (fill != 0) begin
                res.result_kind  = KIND_ISSUE;
                res.out_prop     = shadow_store[shadow_rd].prop;
                res.out_target   = shadow_store[shadow_rd].target;
                res.out_travel   = shadow_store[shadow_rd].travel;
                res.fill_before  = fill[FILL_W-1:0];
                shadow_countdown = shadow_store[shadow_rd].gesture;
                shadow_rd        = next_slot(shadow_rd);
            end
        end
        return res;
    endfunction

    function automatic t_move_req random_payload();
        t_move_req req;
        req.req_type        = 1'($urandom_range(1));
        req.prop_index      = 3'($urandom_range(7));
        req.target_position = 16'($urandom_range(16'hFFFF));
        req.travel_interval = 16'($urandom_range(16'hFFFF));
        req.gesture_ticks   = 16'($urandom_range(16'hFFFF));
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input t_move_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= req;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(predict_queue_result(req));
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        t_move_req req;
        req = random_payload();
        req.req_type = 1'b0;
        send_req(req);
    endtask

    task automatic send_move(input logic [2:0] prop, input logic [15:0] target,
                             input logic [15:0] travel, input logic [15:0] gesture);
        t_move_req req;
        req.req_type        = 1'b1;
        req.prop_index      = prop;
        req.target_position = target;
        req.travel_interval = travel;
        req.gesture_ticks   = gesture;
        send_req(req);
    endtask

    // Hold the sender until every result is back, then let the pipeline settle.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reload(input logic [15:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_reload = value;
        @(negedge i_clk);
    endtask

    // Run the reset countdown out, then let a short reload take over on the empty queue.
    task automatic test_reset_countdown();
        repeat (int'(RESET_RELOAD)) send_tick();
        write_reload(16'd2);
        repeat (3) send_tick();
    endtask

    // Field extremes; the large reload is overridden by the gestures of issued moves.
    task automatic test_edge_moves();
        write_reload(16'hFFFF);
        send_move(3'd0, 16'h0000, 16'h0000, 16'd0);
        send_move(3'd7, 16'hFFFF, 16'hFFFF, 16'd1);
        send_tick();
        send_tick();
        write_reload(16'd0);
        repeat (3) send_tick();
    endtask

    task automatic test_countdown_reload();
        write_reload(16'd3);
        send_move(3'($urandom_range(7)), 16'($urandom), 16'($urandom), 16'd2);
        repeat (3) send_tick();
        send_move(3'($urandom_range(7)), 16'($urandom), 16'($urandom), 16'd0);
        repeat (7) send_tick();
    endtask

    task automatic test_queue_full();
        write_reload(16'd0);
        repeat (DEPTH - 1) begin
            send_move(3'($urandom_range(7)), 16'($urandom), 16'($urandom), 16'd0);
        end
        send_move(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (DEPTH + 2) send_tick();
    endtask

    task automatic test_random_traffic(input int n_items);
        t_move_req req;
        int        enq_pct;
        write_reload(16'($urandom_range(6)));
        enq_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            // vary the mix in bursts so the queue both fills up and runs dry
            if (i % 20 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 25;
                    1: enq_pct = 55;
                    default: enq_pct = 85;
                endcase
            end
            if (i == n_items / 2) wait_idle();
            req = random_payload();
            req.req_type = 1'($urandom_range(99) < enq_pct);
            // keep stored gestures short, or the timer stalls the rest of the run
            if (req.req_type && queued_moves() < DEPTH - 1) begin
                req.gesture_ticks = ($urandom_range(19) == 0) ? 16'($urandom_range(40, 5))
                                                              : 16'($urandom_range(3));
            end
            send_req(req);
        end
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_move_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, kind", out_if.data.result_kind, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.data.result_kind !== want.result_kind)
                    report_mismatch("result_kind", out_if.data.result_kind, want.result_kind);
                if (out_if.data.out_prop !== want.out_prop)
                    report_mismatch("out_prop", out_if.data.out_prop, want.out_prop);
                if (out_if.data.out_target !== want.out_target)
                    report_mismatch("out_target", out_if.data.out_target, want.out_target);
                if (out_if.data.out_travel !== want.out_travel)
                    report_mismatch("out_travel", out_if.data.out_travel, want.out_travel);
                if (out_if.data.fill_before !== want.fill_before)
                    report_mismatch("fill_before", out_if.data.fill_before, want.fill_before);
            end
        end
    end

    initial begin : watchdog
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = 16'd0;
        in_if.valid      = 1'b0;
        in_if.data       = '0;
        out_if.ready     = 1'b0;
        mismatch_count   = 0;
        send_idle_pct    = 24;
        recv_idle_pct    = 63;
        shadow_rd        = 0;
        shadow_wr        = 0;
        shadow_countdown = RESET_RELOAD;
        shadow_reload    = RESET_RELOAD;
        foreach (shadow_store[i]) shadow_store[i] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_countdown();
        test_edge_moves();
        test_countdown_reload();
        test_queue_full();
        test_random_traffic(100);

        send_idle_pct = 63;
        recv_idle_pct = 24;
        test_random_traffic(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
